/* rtl/dmg_pkg.sv */
package dmg_pkg;

  // request and result items
  typedef struct packed {
    logic               chan;
    logic signed [15:0] sample_in;
    logic        [15:0] envelope;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               ticked;
  } out_item_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_RECIPROCAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT  = 3'd4;

  typedef struct packed {
    logic [15:0] level_scale;
    logic [8:0]  level_max;
    logic [15:0] level_reciprocal;
    logic [15:0] gate_threshold;
    logic [24:0] phase_increment;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_scale:      16'd16256,
    level_max:        9'd127,
    level_reciprocal: 16'd1032,
    gate_threshold:   16'd33,
    phase_increment:  25'd1048576
  };

  // datapath widths and constants
  localparam int unsigned PHASE_W = 26;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned OPND_W  = 18;
  localparam int unsigned PROD_W  = 36;
  localparam logic [PHASE_W-1:0]        PHASE_ONE   = 26'h100_0000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 10'sd63;
  localparam logic signed [OPND_W-1:0]  GAIN_ONE    = 18'sh1_0000;

  // microcode
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_S_SCALE,
    MUL_LVL_RECIP,
    MUL_ENV_SCALE,
    MUL_BASE_SQ,
    MUL_RND_SQ,
    MUL_RND_X16,
    MUL_RND_X2,
    MUL_HELD_RND,
    MUL_HELD_ONE
  } mul_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_PHASE,
    WB_LEVEL,
    WB_HELD,
    WB_X2,
    WB_X16
  } wb_e;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_NO_TICK,
    BR_ENV_ABOVE,
    BR_BASE_FULL
  } br_e;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_FIRST    = 4'd1;
  localparam step_t STEP_GATE     = 4'd5;
  localparam step_t STEP_GAIN_ONE = 4'd14;
  localparam step_t STEP_RESULT   = 4'd15;

  typedef struct packed {
    mul_e  mul;
    wb_e   wb;
    br_e   br;
    step_t target;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    logic tick;
    logic env_above;
    logic base_full;
  } dp_stat_t;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    w = '{mul: MUL_NONE, wb: WB_NONE, br: BR_NONE, target: STEP_IDLE, last: 1'b0};
    case (step)
      // modulator clock and quantizer
      4'd1:  w = '{mul: MUL_S_SCALE, wb: WB_PHASE, br: BR_NO_TICK, target: STEP_GATE,
                   last: 1'b0};
      4'd2:  w.wb  = WB_LEVEL;
      4'd3:  w.mul = MUL_LVL_RECIP;
      4'd4:  w.wb  = WB_HELD;
      // gate gain, 50th power by squaring
      4'd5:  w = '{mul: MUL_ENV_SCALE, wb: WB_NONE, br: BR_ENV_ABOVE,
                   target: STEP_GAIN_ONE, last: 1'b0};
      4'd6:  w = '{mul: MUL_BASE_SQ, wb: WB_NONE, br: BR_BASE_FULL,
                   target: STEP_GAIN_ONE, last: 1'b0};
      4'd7:  begin
        w.mul = MUL_RND_SQ;
        w.wb  = WB_X2;
      end
      4'd8:  w.mul = MUL_RND_SQ;
      4'd9:  w.mul = MUL_RND_SQ;
      4'd10: begin
        w.mul = MUL_RND_SQ;
        w.wb  = WB_X16;
      end
      4'd11: w.mul = MUL_RND_X16;
      4'd12: w.mul = MUL_RND_X2;
      4'd13: w = '{mul: MUL_HELD_RND, wb: WB_NONE, br: BR_ALWAYS, target: STEP_RESULT,
                   last: 1'b0};
      4'd14: w.mul = MUL_HELD_ONE;
      4'd15: w.last = 1'b1;
      default: ;
    endcase
    return w;
  endfunction

endpackage

/* rtl/delta_modulator_with_gate.sv */
// a request runs the clock step, the quantizer steps when the clock ticks, and the gate gain;
// the gain runs the full squaring chain for the 50th power unless the envelope or the base gates it to one
// one request at a time: a new request stalls until the result is loaded, as the single shared 18x18
// multiplier is stepped by a 16-word control program
// reset: asynchronous, active low; configuration registers return to their defaults, every channel
// to level 63, held sample 0 and phase 1.0
module delta_modulator_with_gate
  import dmg_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  cfg_t      cfg_q;
  ctrl_t     ctrl;
  dp_stat_t  stat;
  out_item_t res;
  out_item_t out_data_q;
  logic      out_valid_q;
  logic      busy;
  logic      in_accept;
  logic      out_busy;
  logic      out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEVEL_SCALE:      cfg_q.level_scale      <= cfg_data_i[15:0];
        CFG_LEVEL_MAX:        cfg_q.level_max        <= cfg_data_i[8:0];
        CFG_LEVEL_RECIPROCAL: cfg_q.level_reciprocal <= cfg_data_i[15:0];
        CFG_GATE_THRESHOLD:   cfg_q.gate_threshold   <= cfg_data_i[15:0];
        CFG_PHASE_INCREMENT:  cfg_q.phase_increment  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid_i && !busy;
  assign out_busy  = out_valid_q && out_stall_i;
  assign out_load  = ctrl.last && !out_busy;

  dmg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  dmg_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_o       (res)
  );

  // output register parts the result from the next request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer did not start on an accepted request");

  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("sequencer started without a request");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

endmodule

/* rtl/dmg_seq.sv */
module dmg_seq
  import dmg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     out_busy_i,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o,
  output logic     busy_o
);

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  taken;

  always_comb begin
    ctrl = ucode(step_q);
    case (ctrl.br)
      BR_NONE:      taken = 1'b0;
      BR_ALWAYS:    taken = 1'b1;
      BR_NO_TICK:   taken = !stat_i.tick;
      BR_ENV_ABOVE: taken = stat_i.env_above;
      BR_BASE_FULL: taken = stat_i.base_full;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    if (step_q == STEP_IDLE) begin
      step_d = start_i ? STEP_FIRST : STEP_IDLE;
    end else if (ctrl.last) begin
      // hold the last step until the output register is free
      step_d = out_busy_i ? step_q : STEP_IDLE;
    end else if (taken) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (step_q != STEP_IDLE);

endmodule

/* rtl/dmg_datapath.sv */
module dmg_datapath
  import dmg_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_accept_i,
  input  in_item_t  in_data_i,
  input  ctrl_t     ctrl_i,
  output dp_stat_t  stat_o,
  output out_item_t res_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic signed [15:0] sat16(logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(32767)) return 16'sh7fff;
    if (v < -PROD_W'(32768)) return 16'sh8000;
    return v[15:0];
  endfunction

  // per-channel state
  logic signed [LEVEL_W-1:0] level_q [CHANNELS];
  logic signed [15:0]        held_q  [CHANNELS];
  logic        [PHASE_W-1:0] phase_q [CHANNELS];

  // working registers
  logic [CH_W-1:0]           ch_q;
  logic signed [15:0]        s_q;
  logic [15:0]               env_q;
  logic                      tick_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [16:0]               x2_q, x16_q;

  logic [CH_W-1:0]           ch_d;
  logic signed [LEVEL_W-1:0] lvl_cur, lvl_new;
  logic signed [15:0]        held_cur;
  logic [PHASE_W-1:0]        ph_cur, ph_base, ph_new;
  logic [PHASE_W:0]          ph_sum;
  logic                      tick;
  logic signed [OPND_W-1:0]  opa, opb;
  logic [PROD_W-1:0]         rnd_sum, base_sum;
  logic [16:0]               rnd_val;
  logic [25:0]               base_val;
  logic signed [PROD_W-1:0]  xq, xc, hi, t1, rs;
  logic [PROD_W-1:0]         tgt_sum;
  logic [LEVEL_W-1:0]        target;

  always_comb begin
    ch_d     = (CHANNELS > 1) ? CH_W'(in_data_i.chan) : '0;
    lvl_cur  = level_q[ch_q];
    held_cur = held_q[ch_q];
    ph_cur   = phase_q[ch_q];

    // modulator clock
    tick    = (ph_cur >= PHASE_ONE);
    ph_base = tick ? ph_cur - PHASE_ONE : ph_cur;
    ph_sum  = {1'b0, ph_base} + {2'b00, cfg_i.phase_increment};
    ph_new  = ph_sum[PHASE_W] ? '1 : ph_sum[PHASE_W-1:0];

    // rounding taps off the product register
    rnd_sum  = prod_q + PROD_W'(32768);
    rnd_val  = rnd_sum[32:16];
    base_sum = prod_q + PROD_W'(64);
    base_val = base_sum[32:7];

    // quantizer: clamp then round half up
    xq = prod_q + $signed({5'b0, cfg_i.level_scale, 15'b0});
    hi = $signed({4'b0, cfg_i.level_max, 23'b0});
    if (xq < 0) begin
      xc = '0;
    end else if (xq > hi) begin
      xc = hi;
    end else begin
      xc = xq;
    end
    tgt_sum = xc + PROD_W'(32'h40_0000);
    target  = tgt_sum[32:23];
    if ($signed({1'b0, target}) > $signed({lvl_cur[LEVEL_W-1], lvl_cur})) begin
      lvl_new = lvl_cur + LEVEL_W'(1);
    end else begin
      lvl_new = lvl_cur - LEVEL_W'(1);
    end

    // held sample: floor((level*reciprocal - 65536 + 1) / 2)
    t1 = prod_q - PROD_W'(65535);
    // output: floor((held*gain + 32768) / 65536)
    rs = prod_q + PROD_W'(32768);
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl_i.mul)
      MUL_S_SCALE: begin
        opa = {{2{s_q[15]}}, s_q};
        opb = {2'b00, cfg_i.level_scale};
      end
      MUL_LVL_RECIP: begin
        opa = {{(OPND_W-LEVEL_W){lvl_cur[LEVEL_W-1]}}, lvl_cur};
        opb = {2'b00, cfg_i.level_reciprocal};
      end
      MUL_ENV_SCALE: begin
        opa = {2'b00, env_q};
        opb = {2'b00, cfg_i.level_scale};
      end
      MUL_BASE_SQ: begin
        opa = {2'b00, base_val[15:0]};
        opb = {2'b00, base_val[15:0]};
      end
      MUL_RND_SQ: begin
        opa = {1'b0, rnd_val};
        opb = {1'b0, rnd_val};
      end
      MUL_RND_X16: begin
        opa = {1'b0, rnd_val};
        opb = {1'b0, x16_q};
      end
      MUL_RND_X2: begin
        opa = {1'b0, rnd_val};
        opb = {1'b0, x2_q};
      end
      MUL_HELD_RND: begin
        opa = {{2{held_cur[15]}}, held_cur};
        opb = {1'b0, rnd_val};
      end
      MUL_HELD_ONE: begin
        opa = {{2{held_cur[15]}}, held_cur};
        opb = GAIN_ONE;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod_d = opa * opb;
  end

  // request latch and scratch registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      ch_q  <= ch_d;
      s_q   <= in_data_i.sample_in;
      env_q <= in_data_i.envelope;
    end
    if (ctrl_i.mul != MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.wb == WB_PHASE) begin
      tick_q <= tick;
    end
    if (ctrl_i.wb == WB_X2) begin
      x2_q <= rnd_val;
    end
    if (ctrl_i.wb == WB_X16) begin
      x16_q <= rnd_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i] <= LEVEL_RESET;
        held_q[i]  <= '0;
        phase_q[i] <= PHASE_ONE;
      end
    end else begin
      case (ctrl_i.wb)
        WB_PHASE: phase_q[ch_q] <= ph_new;
        WB_LEVEL: level_q[ch_q] <= lvl_new;
        WB_HELD:  held_q[ch_q]  <= sat16(t1 >>> 1);
        default: ;
      endcase
    end
  end

  assign stat_o.tick      = tick;
  assign stat_o.env_above = (env_q > cfg_i.gate_threshold);
  assign stat_o.base_full = |base_val[25:16];

  assign res_o.sample_out = sat16(rs >>> 16);
  assign res_o.ticked     = tick_q;

endmodule
